@@ hdl/iira_pkg.sv @@
// shared constants, operation and status codes, and the controller/datapath
// command and status structs for the indexed insert/remove array
// no dependencies
package iira_pkg;

  localparam int CAPACITY  = 256;
  localparam int WORD_BITS = 32;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // fixed field widths of the stream beats
  localparam int OP_W     = 3;
  localparam int POS_W    = 9;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 9;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((STAT_W + VAL_W + COUNT_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_GET    = 3'd3;
  localparam logic [OP_W-1:0] OP_SET    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOB  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load_req;   // capture the request beat
    logic ptr_init;   // load the shift pointer
    logic ptr_step;   // move the shift pointer one place
    logic mem_rd;     // read the store into the read register
    logic rd_at_pos;  // read address is the request position, else the pointer
    logic mem_wr;     // write the store
    logic wr_put;     // write the request word at its position, else shift
    logic finish;     // update the count and load the result register
  } iira_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok;
    logic            shift_none;
    logic            shift_last;
    logic            out_busy;
  } iira_status_t;

endpackage

@@ hdl/iira_dp.sv @@
// datapath: request register, entry store with registered read, shift pointer,
// fill count and result register; depends on iira_pkg
module iira_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iira_pkg::iira_cmd_t           cmd,
  output iira_pkg::iira_status_t        st,
  input  logic [iira_pkg::OP_W-1:0]     req_type,
  input  logic [iira_pkg::POS_W-1:0]    position,
  input  logic signed [iira_pkg::VAL_W-1:0] write_value,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [iira_pkg::STAT_W-1:0]   result_status,
  output logic signed [iira_pkg::VAL_W-1:0] read_value,
  output logic [iira_pkg::COUNT_W-1:0]  entry_count
);
  import iira_pkg::*;

  logic [OP_W-1:0]             req_op_r;
  logic [POS_W-1:0]            req_pos_r;
  logic signed [WORD_BITS-1:0] req_val_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [ADDR_W-1:0]           ptr_r, ptr_nxt;
  logic signed [WORD_BITS-1:0] mem [CAPACITY];
  logic signed [WORD_BITS-1:0] rd_data_r;
  logic                        out_valid_r;
  logic [STAT_W-1:0]           out_status_r;
  logic signed [VAL_W-1:0]     out_read_r;
  logic [COUNT_W-1:0]          out_count_r;

  logic [CMP_W-1:0]  pos_ext, cnt_ext, eff_pos;
  logic              is_ins;
  logic [STAT_W-1:0] stat;
  logic [ADDR_W-1:0] ptr_start, rd_addr, wr_addr, shift_dest;
  logic signed [WORD_BITS-1:0] wr_data;
  logic              ptr_at_end;

  assign pos_ext = CMP_W'(req_pos_r);
  assign cnt_ext = CMP_W'(count_r);
  assign is_ins  = (req_op_r == OP_INSERT) || (req_op_r == OP_APPEND);
  assign eff_pos = (req_op_r == OP_APPEND) ? cnt_ext : pos_ext;

  // bounds check comes before the full check
  always_comb begin
    stat = ST_OK;
    case (req_op_r)
      OP_INSERT, OP_APPEND: begin
        if (eff_pos > cnt_ext) stat = ST_OOB;
        else if (count_r >= CNT_W'(CAPACITY)) stat = ST_FULL;
      end
      OP_REMOVE, OP_GET, OP_SET: begin
        if (pos_ext >= cnt_ext) stat = ST_OOB;
      end
      default: stat = ST_OK;
    endcase
  end

  // insert walks down from the last entry, remove walks up from the one after pos
  assign ptr_start  = is_ins ? ADDR_W'(count_r - CNT_W'(1)) : ADDR_W'(req_pos_r + POS_W'(1));
  assign ptr_at_end = is_ins ? (ptr_r == ADDR_W'(eff_pos))
                             : (ptr_r == ADDR_W'(count_r - CNT_W'(1)));
  assign shift_dest = is_ins ? (ptr_r + ADDR_W'(1)) : (ptr_r - ADDR_W'(1));
  assign ptr_nxt    = cmd.ptr_init ? ptr_start : (is_ins ? ptr_r - ADDR_W'(1) : ptr_r + ADDR_W'(1));

  assign rd_addr = cmd.rd_at_pos ? ADDR_W'(req_pos_r) : ptr_r;
  assign wr_addr = cmd.wr_put ? ADDR_W'(eff_pos) : shift_dest;
  assign wr_data = cmd.wr_put ? req_val_r : rd_data_r;

  always_comb begin
    st.op         = req_op_r;
    st.ok         = (stat == ST_OK);
    st.shift_none = is_ins ? (eff_pos == cnt_ext) : (CMP_W'(pos_ext + CMP_W'(1)) == cnt_ext);
    st.shift_last = ptr_at_end;
    st.out_busy   = out_valid_r && !out_tready;
  end

  always_comb begin
    count_nxt = count_r;
    if (stat == ST_OK) begin
      case (req_op_r)
        OP_INSERT, OP_APPEND: count_nxt = count_r + CNT_W'(1);
        OP_REMOVE:            count_nxt = count_r - CNT_W'(1);
        OP_CLEAR:             count_nxt = '0;
        default:              count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op_r  <= req_type;
      req_pos_r <= position;
      req_val_r <= WORD_BITS'(write_value);
    end
    if (cmd.ptr_init || cmd.ptr_step) ptr_r <= ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[wr_addr] <= wr_data;
    if (cmd.mem_rd) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= stat;
      out_read_r   <= (req_op_r == OP_GET && stat == ST_OK) ? VAL_W'(rd_data_r) : '0;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign result_status = out_status_r;
  assign read_value    = out_read_r;
  assign entry_count   = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> (CMP_W'(wr_addr) <= cnt_ext))
    else $error("store write beyond the held entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && !out_tready))
    else $error("result register loaded while a beat is still waiting");

endmodule

@@ hdl/iira_ctrl.sv @@
// controller state machine: sequences the shift, put, get and finish steps
// of one request; depends on iira_pkg
module iira_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  iira_pkg::iira_status_t st,
  output iira_pkg::iira_cmd_t    cmd
);
  import iira_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SH_RD  = 3'd2;
  localparam logic [2:0] S_SH_WR  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_GET_RD = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!st.ok) begin
          state_nxt = S_FIN;
        end else begin
          case (st.op)
            OP_INSERT, OP_APPEND: begin
              cmd.ptr_init = 1'b1;
              state_nxt    = st.shift_none ? S_PUT : S_SH_RD;
            end
            OP_REMOVE: begin
              cmd.ptr_init = 1'b1;
              state_nxt    = st.shift_none ? S_FIN : S_SH_RD;
            end
            OP_GET:  state_nxt = S_GET_RD;
            OP_SET:  state_nxt = S_PUT;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_SH_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.mem_wr = 1'b1;
        if (st.shift_last) begin
          state_nxt = (st.op == OP_REMOVE) ? S_FIN : S_PUT;
        end else begin
          cmd.ptr_step = 1'b1;
          state_nxt    = S_SH_RD;
        end
      end
      S_PUT: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_put = 1'b1;
        state_nxt  = S_FIN;
      end
      S_GET_RD: begin
        cmd.mem_rd    = 1'b1;
        cmd.rd_at_pos = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_WR) |-> ($past(state_r) == S_SH_RD))
    else $error("shift write without its read");

  a_put_only_ins_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> (st.ok && (st.op == OP_INSERT || st.op == OP_APPEND ||
                                       st.op == OP_SET)))
    else $error("store written for a request that must not change it");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !st.out_busy) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after finishing");

endmodule

@@ hdl/indexed_insert_remove_array.sv @@
// indexed insert/remove array: a request runs decide then finish (clear, errors, remove
// of the last entry), decide, a put or get step, then finish (get, set, insert at the end),
// or for k moved entries k shift steps before the put (insert) or the finish (remove);
// each moved entry costs one read and one write of the single-port-pair store.
// the result beat is registered and a new request is taken while it waits.
// reset (rst_n, synchronous, active low) empties the list; the store itself is not cleared
module indexed_insert_remove_array (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [iira_pkg::IN_TDATA_W-1:0]   in_tdata,   // position, write_value
  input  logic [iira_pkg::OP_W-1:0]         in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [iira_pkg::OUT_TDATA_W-1:0]  out_tdata   // result_status, read_value, entry_count
);
  import iira_pkg::*;

  iira_cmd_t           cmd;
  iira_status_t        st;
  logic [STAT_W-1:0]   result_status;
  logic signed [VAL_W-1:0] read_value;
  logic [COUNT_W-1:0]  entry_count;

  iira_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  iira_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .req_type      (in_tuser),
    .position      (in_tdata[POS_W-1:0]),
    .write_value   (in_tdata[POS_W+VAL_W-1:POS_W]),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .result_status (result_status),
    .read_value    (read_value),
    .entry_count   (entry_count)
  );

  assign out_tdata = OUT_TDATA_W'({entry_count, read_value, result_status});

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for indexed_insert_remove_array; a directed request table,
// then random request blocks, every result beat checked against a typed expectation or an in-bench list model
// depends on iira_pkg and the indexed_insert_remove_array rtl
module tb_top;
  import iira_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;
  localparam int POS_MAX      = (1 << POS_W) - 1;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   rd_word;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] word;
    logic             typed;
    list_result_t     res;
  } plan_row_t;

  localparam logic TYPED = 1'b1;
  localparam logic MODEL = 1'b0;
  localparam list_result_t NO_RES = '0;
  localparam int PLAN_ROWS = 25;

  plan_row_t plan [PLAN_ROWS] = '{
    '{OP_GET,    9'd0,   32'd0,          TYPED, '{ST_OOB, 32'd0, 9'd0}},
    '{OP_REMOVE, 9'd0,   32'd0,          TYPED, '{ST_OOB, 32'd0, 9'd0}},
    '{OP_SET,    9'd0,   32'd1,          TYPED, '{ST_OOB, 32'd0, 9'd0}},
    '{OP_INSERT, 9'd1,   32'd7,          TYPED, '{ST_OOB, 32'd0, 9'd0}},
    '{OP_INSERT, 9'd0,   32'h8000_0000,  TYPED, '{ST_OK,  32'd0, 9'd1}},
    '{OP_APPEND, 9'd511, 32'h7fff_ffff,  TYPED, '{ST_OK,  32'd0, 9'd2}},
    '{OP_INSERT, 9'd2,   32'hffff_ffff,  TYPED, '{ST_OK,  32'd0, 9'd3}},
    '{OP_INSERT, 9'd1,   32'd0,          TYPED, '{ST_OK,  32'd0, 9'd4}},
    '{OP_GET,    9'd0,   32'hffff_ffff,  TYPED, '{ST_OK,  32'h8000_0000, 9'd4}},
    '{OP_GET,    9'd1,   32'hffff_ffff,  TYPED, '{ST_OK,  32'd0, 9'd4}},
    '{OP_GET,    9'd2,   32'd0,          TYPED, '{ST_OK,  32'h7fff_ffff, 9'd4}},
    '{OP_GET,    9'd3,   32'd0,          TYPED, '{ST_OK,  32'hffff_ffff, 9'd4}},
    '{OP_GET,    9'd4,   32'd0,          TYPED, '{ST_OOB, 32'd0, 9'd4}},
    '{OP_INSERT, 9'd5,   32'd9,          TYPED, '{ST_OOB, 32'd0, 9'd4}},
    '{OP_SET,    9'd3,   32'h5a5a_a5a5,  TYPED, '{ST_OK,  32'd0, 9'd4}},
    '{OP_GET,    9'd3,   32'd0,          MODEL, NO_RES},
    '{OP_REMOVE, 9'd0,   32'd0,          TYPED, '{ST_OK,  32'd0, 9'd3}},
    '{OP_GET,    9'd0,   32'd0,          MODEL, NO_RES},
    '{OP_REMOVE, 9'd2,   32'd0,          TYPED, '{ST_OK,  32'd0, 9'd2}},
    '{OP_GET,    9'd511, 32'd0,          TYPED, '{ST_OOB, 32'd0, 9'd2}},
    '{OP_INSERT, 9'd511, 32'd3,          TYPED, '{ST_OOB, 32'd0, 9'd2}},
    '{OP_SPARE6, 9'd0,   32'd0,          TYPED, '{ST_OK,  32'd0, 9'd2}},
    '{OP_SPARE7, 9'd511, 32'hffff_ffff,  TYPED, '{ST_OK,  32'd0, 9'd2}},
    '{OP_GET,    9'd1,   32'd0,          MODEL, NO_RES},
    '{OP_CLEAR,  9'd0,   32'd0,          TYPED, '{ST_OK,  32'd0, 9'd0}}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic                   hold_off_req = 1'b0;

  // list model state
  logic [VAL_W-1:0]       list_words [CAPACITY];
  int unsigned            list_len = 0;
  list_result_t           pending_results [$];

  int                     burst_left = 0;
  int                     items_sent = 0;
  int                     mismatches = 0;
  int                     idle_cycles = 0;

  indexed_insert_remove_array dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic [VAL_W-1:0] word);
    list_result_t r;
    int unsigned at;
    r = NO_RES;
    at = 32'(pos);
    case (op)
      OP_INSERT, OP_APPEND: begin
        if (op == OP_APPEND) at = list_len;
        // position check wins over the full check
        if (at > list_len) begin
          r.status = ST_OOB;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = int'(list_len); i > int'(at); i--) list_words[i] = list_words[i-1];
          list_words[at] = word;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (at >= list_len) begin
          r.status = ST_OOB;
        end else begin
          for (int i = int'(at); i + 1 < int'(list_len); i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OP_GET: begin
        if (at >= list_len) r.status = ST_OOB;
        else r.rd_word = list_words[at];
      end
      OP_SET: begin
        if (at >= list_len) r.status = ST_OOB;
        else list_words[at] = word;
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly within 0..count, now and then anywhere in the field
  function automatic logic [POS_W-1:0] rand_pos();
    if ($urandom_range(0, 6) == 0) return POS_W'($urandom_range(0, POS_MAX));
    return POS_W'($urandom_range(0, list_len));
  endfunction

  // drives one request beat from a falling edge, returns at the falling edge after acceptance
  task automatic offer(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                       input logic [VAL_W-1:0] word, input logic typed,
                       input list_result_t typed_res);
    list_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = IN_TDATA_W'({word, pos});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = list_apply(op, pos, word);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic mixed_request();
    logic [OP_W-1:0] op;
    int w;
    w = $urandom_range(0, 99);
    if (w < 18)      op = OP_INSERT;
    else if (w < 30) op = OP_APPEND;
    else if (w < 58) op = OP_REMOVE;
    else if (w < 76) op = OP_GET;
    else if (w < 94) op = OP_SET;
    else if (w < 96) op = OP_CLEAR;
    else if (w < 98) op = OP_SPARE6;
    else             op = OP_SPARE7;
    offer(op, rand_pos(), rand_word(), MODEL, NO_RES);
  endtask

  initial begin : stimulus
    int kind;
    int blk;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) offer(plan[i].op, plan[i].pos, plan[i].word, plan[i].typed, plan[i].res);

    blk = 0;
    while (items_sent < PLAN_ROWS + RANDOM_ITEMS) begin
      kind = (blk == 0) ? 0 : $urandom_range(0, 9);
      if (blk == 3) hold_off_req = 1'b1;
      case (kind)
        0: begin
          while (list_len < CAPACITY) begin
            if ($urandom_range(0, 15) == 0)
              offer(OP_INSERT, POS_W'($urandom_range(0, list_len)), rand_word(), MODEL, NO_RES);
            else
              offer(OP_APPEND, POS_W'($urandom_range(0, POS_MAX)), rand_word(), MODEL, NO_RES);
          end
          // full list refuses inserts, but a position past the end is still out of bounds
          offer(OP_APPEND, rand_pos(), rand_word(), MODEL, NO_RES);
          offer(OP_INSERT, POS_W'($urandom_range(0, CAPACITY)), rand_word(), MODEL, NO_RES);
          offer(OP_INSERT, POS_W'($urandom_range(CAPACITY + 1, POS_MAX)), rand_word(),
                MODEL, NO_RES);
          offer(OP_GET, POS_W'(CAPACITY - 1), rand_word(), MODEL, NO_RES);
          offer(OP_REMOVE, POS_W'($urandom_range(0, CAPACITY - 1)), rand_word(), MODEL, NO_RES);
        end
        1: begin
          offer(OP_CLEAR, rand_pos(), rand_word(), MODEL, NO_RES);
          repeat ($urandom_range(1, 8)) mixed_request();
        end
        9: begin
          repeat ($urandom_range(5, 30))
            offer(OP_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, POS_MAX)), $urandom,
                  MODEL, NO_RES);
        end
        default: repeat ($urandom_range(10, 60)) mixed_request();
      endcase
      // let the block run dry now and then, but keep offering through the long hold
      if ((blk == 1 || (blk != 3 && $urandom_range(0, 7) == 0)) &&
          pending_results.size() != 0) begin
        in_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      blk++;
    end

    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("indexed_insert_remove_array verification clean");
    end else begin
      $display("indexed_insert_remove_array verification failed");
    end
    $finish;
  end

  // result side back-pressure, with a pattern picked at random for each stretch
  initial begin : result_sink
    int mode;
    int mode_left;
    int run_left;
    logic ready_now;
    mode = 0;
    mode_left = 0;
    run_left = 0;
    ready_now = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // long hold so the result register fills and the input stalls
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = $urandom_range(0, 1);
        2: out_tready = ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            ready_now = !ready_now;
            run_left = $urandom_range(1, 10);
          end
          run_left--;
          out_tready = ready_now;
        end
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = out_tdata[STAT_W-1:0];
      got.rd_word = out_tdata[STAT_W +: VAL_W];
      got.count   = out_tdata[STAT_W+VAL_W +: COUNT_W];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result beat: status %0d word %h count %0d",
                   got.status, got.rd_word, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.rd_word !== want.rd_word ||
            got.count !== want.count) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"result mismatch: expected status %0d word %h count %0d, ",
                      "got status %0d word %h count %0d"},
                     want.status, want.rd_word, want.count,
                     got.status, got.rd_word, got.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("indexed_insert_remove_array verification failed");
      $finish;
    end
  end

endmodule
